// ===== sv/egre_pkg.sv =====
package egre_pkg;

    localparam int unsigned STREAMS_DEF = 4;
    localparam int unsigned AW = 48;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_RESP  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        PH_INVALID        = 3'd0,
        PH_READING_INDEX  = 3'd1,
        PH_READ_NEXT      = 3'd2,
        PH_READING_WEIGHT = 3'd3,
        PH_WRITE_NEXT     = 3'd4,
        PH_WRITING        = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNEXP = 2'd1,
        ERR_RANGE = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_RUN  = 3'b010,
        MODE_DONE = 3'b100
    } t_mode;

    localparam logic [2:0] REG_INDEX_BASE  = 3'd0;
    localparam logic [2:0] REG_WEIGHT_BASE = 3'd1;
    localparam logic [2:0] REG_OUTPUT_BASE = 3'd2;
    localparam logic [2:0] REG_TABLE_ROWS  = 3'd3;
    localparam logic [2:0] REG_ROW_WIDTH   = 3'd4;
    localparam logic [2:0] REG_FIRST_ROW   = 3'd5;
    localparam logic [2:0] REG_END_ROW     = 3'd6;

    localparam logic [3:0] BYTES_INDEX = 4'd8;
    localparam logic [3:0] BYTES_WORD  = 4'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic        port_accepts;
        logic [3:0]  resp_stream;
        logic [63:0] resp_data;
    } t_item;

    typedef struct packed {
        logic        req_valid;
        logic        req_write;
        logic [47:0] req_addr;
        logic [3:0]  req_bytes;
        logic [3:0]  req_stream;
        logic [31:0] req_data;
        logic        done_res;
        logic [1:0]  error;
    } t_result;

endpackage

// ===== sv/egre_front.sv =====
module egre_front
    import egre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [70:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_item       o_item
);

    t_item r_q0, r_q1;
    logic [1:0] r_cnt;
    t_item w_in;
    logic w_push, w_pop;

    assign w_in.action       = i_data[1:0];
    assign w_in.port_accepts = i_data[2];
    assign w_in.resp_stream  = i_data[6:3];
    assign w_in.resp_data    = i_data[70:7];

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_pop) begin
            r_q0 <= (r_cnt == 2'd2) ? r_q1 : w_in;
        end else if (w_push && r_cnt == 2'd0) begin
            r_q0 <= w_in;
        end
        if (w_push && ((r_cnt == 2'd1 && !w_pop) || (r_cnt == 2'd2))) begin
            r_q1 <= w_in;
        end
    end

endmodule

// ===== sv/egre_back.sv =====
module egre_back
    import egre_pkg::*;
#(
    parameter int unsigned STREAMS = STREAMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_res
);

    localparam int unsigned SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    logic [47:0] r_ib, r_wb, r_ob, r_jib, r_jwb, r_job;
    logic [31:0] r_trows, r_first, r_end, r_jrows, r_jend;
    logic [15:0] r_width, r_jwidth;
    t_mode       r_mode;
    logic [SW-1:0] r_turn;
    t_phase      r_ph [STREAMS];
    logic [31:0] r_row [STREAMS];
    logic [16:0] r_col [STREAMS];
    logic [31:0] r_trow [STREAMS];
    logic [31:0] r_val [STREAMS];
    logic [47:0] r_rd, r_wr, r_tot;
    logic        r_ov;
    t_result     r_res;

    logic        w_go;
    logic [SW-1:0] w_s, w_rs;
    logic        w_rs_ok;
    logic [31:0] w_nr;
    logic [47:0] w_mul_a;
    logic [63:0] w_prod;
    logic [47:0] w_addr;
    logic [16:0] w_c;

    assign o_ready = !r_ov || i_ready;
    assign w_go    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    assign w_s  = r_turn;
    assign w_rs = i_item.resp_stream[SW-1:0];
    assign w_rs_ok = ({28'd0, i_item.resp_stream} < 32'(STREAMS));
    assign w_nr = r_row[w_s] + ((r_ph[w_s] != PH_INVALID) ? 32'd1 : 32'd0);
    assign w_mul_a = (r_ph[w_s] == PH_READ_NEXT) ? {16'd0, r_trow[w_s]}
                                                  : {16'd0, r_row[w_s]};
    assign w_prod = 64'(w_mul_a) * 64'(r_jwidth) + 64'(r_col[w_s]);
    assign w_c = (r_col[w_rs] + 17'(STREAMS) > {1'b0, r_jwidth}) ?
                 {1'b0, r_jwidth} : r_col[w_rs] + 17'(STREAMS);

    always_comb begin
        w_addr = 48'd0;
        if (r_ph[w_s] == PH_READ_NEXT) w_addr = r_jwb + {w_prod[45:0], 2'b00};
        else w_addr = r_job + {w_prod[45:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin : p_seq
        t_result n_res;
        if (!i_rst_n) begin
            r_ib <= '0; r_wb <= '0; r_ob <= '0;
            r_trows <= 32'd1; r_width <= 16'd4; r_first <= '0; r_end <= '0;
            r_jib <= '0; r_jwb <= '0; r_job <= '0;
            r_jrows <= 32'd1; r_jwidth <= 16'd4; r_jend <= '0;
            r_mode <= MODE_IDLE; r_turn <= '0;
            r_rd <= '0; r_wr <= '0; r_tot <= '0;
            r_ov <= 1'b0;
            for (int i = 0; i < STREAMS; i++) begin
                r_ph[i] <= PH_INVALID; r_row[i] <= '0; r_col[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_INDEX_BASE:  r_ib <= i_cfg_data[47:0];
                    REG_WEIGHT_BASE: r_wb <= i_cfg_data[47:0];
                    REG_OUTPUT_BASE: r_ob <= i_cfg_data[47:0];
                    REG_TABLE_ROWS:  r_trows <= i_cfg_data[31:0];
                    REG_ROW_WIDTH:   r_width <= i_cfg_data[15:0];
                    REG_FIRST_ROW:   r_first <= i_cfg_data[31:0];
                    REG_END_ROW:     r_end <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            r_ov <= w_go || (r_ov && !i_ready);
            if (w_go) begin
                n_res = '0;
                n_res.done_res = (r_mode == MODE_DONE);
                case (t_action'(i_item.action))
                    ACT_START: begin
                        r_jib <= r_ib; r_jwb <= r_wb; r_job <= r_ob;
                        r_jrows <= r_trows; r_jwidth <= r_width;
                        r_jend <= (r_end < r_first) ? r_first : r_end;
                        r_tot <= 48'(64'((r_end < r_first) ? 32'd0 : r_end - r_first)
                                 * 64'(r_width));
                        r_rd <= '0; r_wr <= '0; r_mode <= MODE_RUN;
                        n_res.done_res = 1'b0;
                        for (int i = 0; i < STREAMS; i++) begin
                            r_ph[i] <= PH_INVALID; r_col[i] <= 17'(i); r_row[i] <= r_first;
                        end
                    end
                    ACT_TICK: begin
                        if (r_mode == MODE_RUN) begin
                            if (r_rd == r_tot && r_wr == r_tot) begin
                                r_mode <= MODE_DONE;
                                n_res.done_res = 1'b1;
                            end else if (r_row[w_s] == r_jend) begin
                                r_turn <= (32'(r_turn) == STREAMS - 1) ? '0 : r_turn + 1'b1;
                            end else if (r_ph[w_s] == PH_READING_INDEX ||
                                         r_ph[w_s] == PH_READING_WEIGHT ||
                                         r_ph[w_s] == PH_WRITING) begin
                            end else if (r_ph[w_s] == PH_INVALID ||
                                         r_col[w_s] >= {1'b0, r_jwidth}) begin
                                if (w_nr == r_jend) begin
                                    r_row[w_s] <= w_nr;
                                    r_turn <= (32'(r_turn) == STREAMS - 1) ? '0 : r_turn + 1'b1;
                                end else if (i_item.port_accepts) begin
                                    r_row[w_s] <= w_nr;
                                    r_ph[w_s] <= PH_READING_INDEX;
                                    n_res.req_valid = 1'b1;
                                    n_res.req_addr = r_jib + {13'd0, w_nr, 3'b000};
                                    n_res.req_bytes = BYTES_INDEX;
                                    n_res.req_stream = 4'(w_s);
                                    r_turn <= (32'(r_turn) == STREAMS - 1) ? '0 : r_turn + 1'b1;
                                end
                            end else if (i_item.port_accepts) begin
                                n_res.req_valid = 1'b1;
                                n_res.req_addr = w_addr;
                                n_res.req_bytes = BYTES_WORD;
                                n_res.req_stream = 4'(w_s);
                                r_turn <= (32'(r_turn) == STREAMS - 1) ? '0 : r_turn + 1'b1;
                                if (r_ph[w_s] == PH_READ_NEXT) begin
                                    r_ph[w_s] <= PH_READING_WEIGHT;
                                end else begin
                                    r_ph[w_s] <= PH_WRITING;
                                    n_res.req_write = 1'b1;
                                    n_res.req_data = r_val[w_s];
                                end
                            end
                        end
                    end
                    ACT_RESP: begin
                        if (r_mode != MODE_RUN || !w_rs_ok) begin
                            n_res.error = ERR_UNEXP;
                        end else begin
                            case (r_ph[w_rs])
                                PH_READING_INDEX: begin
                                    r_trow[w_rs] <= i_item.resp_data[31:0];
                                    if (i_item.resp_data >= {32'd0, r_jrows})
                                        n_res.error = ERR_RANGE;
                                    r_col[w_rs] <= 17'(w_rs);
                                    r_ph[w_rs] <= PH_READ_NEXT;
                                end
                                PH_READING_WEIGHT: begin
                                    r_val[w_rs] <= i_item.resp_data[31:0];
                                    r_rd <= r_rd + 48'd1;
                                    r_ph[w_rs] <= PH_WRITE_NEXT;
                                end
                                PH_WRITING: begin
                                    r_col[w_rs] <= w_c;
                                    r_wr <= r_wr + 48'd1;
                                    r_ph[w_rs] <= PH_READ_NEXT;
                                end
                                default: n_res.error = ERR_UNEXP;
                            endcase
                        end
                    end
                    default: ;
                endcase
                r_res <= n_res;
            end
        end
    end

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_res));
    endproperty
    assert property (p_hold) else $error("result changed while stalled");

    property p_done_no_req;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_res.done_res) |-> !r_res.req_valid;
    endproperty
    assert property (p_done_no_req) else $error("request with done");

    property p_cnt;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_DONE) |-> (r_rd == r_tot);
    endproperty
    assert property (p_cnt) else $error("done before reads");

    property p_wr_data;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_res.req_write) |-> (r_res.req_data == 32'd0);
    endproperty
    assert property (p_wr_data) else $error("data on read");

endmodule

// ===== sv/embedding_gather_request_engine_core.sv =====
// Embedding gather request engine.
// Input stream s_axis: tdata holds action[1:0], port_accepts[2], resp_stream[6:3],
// resp_data[70:7]. Action start latches the configuration into a new job, a tick
// lets the round-robin stream issue one memory request, a response advances the
// stream that it names.
// Output stream m_axis: one transaction per accepted input, carrying the request
// fields, the done flag and the error code.
// Configuration channel: index and data, written by the user only while the engine
// is idle; the engine itself does not enforce this.
// An item passes a two-entry input queue and one output register; one item per cycle
// is sustained while m_axis_tready is high, set by the per-item update of the chosen
// stream's state. A stalled receiver holds the output register; the queue then fills
// and s_axis_tready falls once it holds two items.
// Reset returns the engine to idle with the configuration at its reset values.
module embedding_gather_request_engine_core
    import egre_pkg::*;
#(
    parameter int unsigned STREAMS = STREAMS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // action, port_accepts, resp_stream, resp_data
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // req_valid, req_write, req_addr, req_bytes,
                                         // req_stream, req_data, done_res, error
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    t_item   w_item;
    t_result w_res;
    logic    w_qv, w_qr;

    assign o_cfg_ready = 1'b1;

    egre_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata[70:0]),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_item)
    );

    egre_back #(.STREAMS(STREAMS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_item(w_item),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {3'd0, w_res.error, w_res.done_res, w_res.req_data,
                           w_res.req_stream, w_res.req_bytes, w_res.req_addr,
                           w_res.req_write, w_res.req_valid};

endmodule
